[rtl/core/i2cram_pkg.sv]
`timescale 1ns / 1ps

package i2cram_pkg;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_WBIT_LO = 4'd3,
    PH_WBIT_HI = 4'd4,
    PH_WACK_LO = 4'd5,
    PH_WACK_HI = 4'd6,
    PH_RBIT_LO = 4'd7,
    PH_RBIT_HI = 4'd8,
    PH_MACK_LO = 4'd9,
    PH_MACK_HI = 4'd10,
    PH_STOP_A  = 4'd11,
    PH_STOP_B  = 4'd12,
    PH_STOP_C  = 4'd13
  } phase_t;

  localparam logic [2:0] BYTE_ADDR   = 3'd0;
  localparam logic [2:0] BYTE_PTR    = 3'd1;
  localparam logic [2:0] BYTE_THIRD  = 3'd2;
  localparam logic [2:0] BYTE_FOURTH = 3'd3;
  localparam logic [2:0] BYTE_RD_LO  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_BUS_ENABLE     = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd64;

  typedef struct packed {
    logic        start_req;
    logic [1:0]  op;
    logic [7:0]  reg_pointer;
    logic [15:0] write_data;
    logic        sda_sample;
  } req_t;

  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [15:0] read_data;
  } res_t;

endpackage

[rtl/core/i2c_register_access_master_unit.sv]
// Each accepted request's result is registered and presented in order of acceptance.
// Throughput: one request per cycle; a two-entry result buffer keeps accepting
// while a result waits, and stall is raised only when both entries are full.
// Reset (synchronous, active high): bus idle with both lines released,
// device_address 64, bus_enable 0, result buffer empty.
`timescale 1ns / 1ps

module i2c_register_access_master_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  i2cram_pkg::req_t   req,
  output logic               res_valid,
  input  logic               res_stall,
  output i2cram_pkg::res_t   res,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);
  import i2cram_pkg::*;

  logic [6:0]  device_address;
  logic        bus_enable;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] read_word, read_word_next;
  logic [1:0]  latched_op, latched_op_next;
  logic [7:0]  latched_pointer, latched_pointer_next;
  logic [15:0] latched_value, latched_value_next;
  logic        all_acked, all_acked_next;

  res_t        result;
  res_t        buf0, buf1;
  logic [1:0]  count;
  logic        push, pop;

  logic        load_byte;
  logic [2:0]  load_idx;
  logic [3:0]  bit_count_inc;

  function automatic logic [7:0] byte_to_send(input logic [2:0] idx, input logic [6:0] addr,
                                               input logic [1:0] lop, input logic [7:0] ptr,
                                               input logic [15:0] val);
    logic [7:0] addr_w;
    addr_w = {addr, 1'b0};
    case (idx)
      BYTE_ADDR:  byte_to_send = addr_w;
      BYTE_PTR:   byte_to_send = ptr;
      BYTE_THIRD: byte_to_send = (lop == OP_READ) ? {addr, 1'b1} : val[15:8];
      default:    byte_to_send = val[7:0];
    endcase
  endfunction

  assign push      = req_valid && !req_stall;
  assign pop       = res_valid && !res_stall;
  assign req_stall = (count == 2'd2);
  assign res_valid = (count != 2'd0);
  assign res       = buf0;
  assign bit_count_inc = bit_count + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      bus_enable     <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DEVICE_ADDRESS) begin
        device_address <= cfg_data;
      end else begin
        bus_enable <= cfg_data[0];
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    byte_index_next      = byte_index;
    shift_byte_next      = shift_byte;
    read_word_next       = read_word;
    latched_op_next      = latched_op;
    latched_pointer_next = latched_pointer;
    latched_value_next   = latched_value;
    all_acked_next       = all_acked;
    load_byte            = 1'b0;
    load_idx             = byte_index;
    result               = '0;
    result.scl_release   = 1'b1;
    result.sda_release   = 1'b1;
    result.busy_res      = 1'b1;

    unique case (phase)
      PH_IDLE: begin
        result.busy_res = 1'b0;
        if (req.start_req) begin
          if (!bus_enable || req.op > OP_READ) begin
            result.done_res = 1'b1;
          end else begin
            latched_op_next      = req.op;
            latched_pointer_next = req.reg_pointer;
            latched_value_next   = req.write_data;
            read_word_next       = '0;
            byte_index_next      = BYTE_ADDR;
            bit_count_next       = '0;
            all_acked_next       = 1'b1;
            result.busy_res      = 1'b1;
            phase_next           = PH_START_B;
          end
        end
      end
      PH_START_A: phase_next = PH_START_B;
      PH_START_B: begin
        result.sda_release = 1'b0;
        load_byte = 1'b1;
        load_idx  = byte_index;
      end
      PH_WBIT_LO: begin
        result.scl_release = 1'b0;
        result.sda_release = shift_byte[7];
        phase_next = PH_WBIT_HI;
      end
      PH_WBIT_HI: begin
        result.sda_release = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_count_inc;
        phase_next = (bit_count_inc >= BITS_PER_BYTE) ? PH_WACK_LO : PH_WBIT_LO;
      end
      PH_WACK_LO: begin
        result.scl_release = 1'b0;
        phase_next = PH_WACK_HI;
      end
      PH_WACK_HI: begin
        if (req.sda_sample) begin
          all_acked_next = 1'b0;
          phase_next = PH_STOP_A;
        end else if (latched_op == OP_WRITE) begin
          if (byte_index < BYTE_FOURTH) begin
            load_byte = 1'b1;
            load_idx  = byte_index + 3'd1;
          end else begin
            phase_next = PH_STOP_A;
          end
        end else if (latched_op == OP_READ) begin
          if (byte_index == BYTE_ADDR) begin
            load_byte = 1'b1;
            load_idx  = BYTE_PTR;
          end else if (byte_index == BYTE_PTR) begin
            byte_index_next = BYTE_THIRD;
            phase_next = PH_START_A;
          end else begin
            byte_index_next = BYTE_FOURTH;
            bit_count_next  = '0;
            phase_next = PH_RBIT_LO;
          end
        end else begin
          phase_next = PH_STOP_A;
        end
      end
      PH_RBIT_LO: begin
        result.scl_release = 1'b0;
        phase_next = PH_RBIT_HI;
      end
      PH_RBIT_HI: begin
        read_word_next = {read_word[14:0], req.sda_sample};
        bit_count_next = bit_count_inc;
        phase_next = (bit_count_inc >= BITS_PER_BYTE) ? PH_MACK_LO : PH_RBIT_LO;
      end
      PH_MACK_LO: begin
        result.scl_release = 1'b0;
        result.sda_release = (byte_index != BYTE_FOURTH);
        phase_next = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        result.sda_release = (byte_index != BYTE_FOURTH);
        if (byte_index == BYTE_FOURTH) begin
          byte_index_next = BYTE_RD_LO;
          bit_count_next  = '0;
          phase_next = PH_RBIT_LO;
        end else begin
          phase_next = PH_STOP_A;
        end
      end
      PH_STOP_A: begin
        result.scl_release = 1'b0;
        result.sda_release = 1'b0;
        phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        result.sda_release = 1'b0;
        phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        result.done_res  = 1'b1;
        result.success   = all_acked;
        result.read_data = (all_acked && latched_op == OP_READ) ? read_word : 16'd0;
        phase_next = PH_IDLE;
      end
      default: begin
        result.busy_res = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase

    if (load_byte) begin
      byte_index_next = load_idx;
      shift_byte_next = byte_to_send(load_idx, device_address, latched_op,
                                     latched_pointer, latched_value);
      bit_count_next  = '0;
      phase_next      = PH_WBIT_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= '0;
      byte_index      <= '0;
      shift_byte      <= '0;
      read_word       <= '0;
      latched_op      <= '0;
      latched_pointer <= '0;
      latched_value   <= '0;
      all_acked       <= 1'b1;
    end else if (push) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      byte_index      <= byte_index_next;
      shift_byte      <= shift_byte_next;
      read_word       <= read_word_next;
      latched_op      <= latched_op_next;
      latched_pointer <= latched_pointer_next;
      latched_value   <= latched_value_next;
      all_acked       <= all_acked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (count == 2'd2) begin
          buf0 <= buf1;
          buf1 <= result;
        end else begin
          buf0 <= result;
        end
      end
      2'b10: begin
        if (count == 2'd0) begin
          buf0 <= result;
        end else begin
          buf1 <= result;
        end
      end
      2'b01: buf0 <= buf1;
      default: ;
    endcase
  end

  // disabled bus or bad op: fail on the launch tick, lines released
  assert property (@(posedge clk) disable iff (rst)
    push && phase == PH_IDLE && req.start_req && !bus_enable
    |-> result.done_res && !result.busy_res && !result.success &&
        result.scl_release && result.sda_release)
    else $error("disabled launch did not fail at once");

  assert property (@(posedge clk) disable iff (rst)
    push && phase == PH_STOP_C |=> phase == PH_IDLE)
    else $error("stop did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.done_res |-> !res.success && res.read_data == 16'd0)
    else $error("status fields set without done");

  assert property (@(posedge clk) disable iff (rst)
    count != 2'd3 && bit_count <= BITS_PER_BYTE)
    else $error("buffer count or bit count out of range");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop && count == 2'd0 |=> res_valid && count == 2'd1)
    else $error("result not presented after accept");

endmodule

[dv/i2c_register_access_master_unit_tb.sv]
`timescale 1ns / 1ps

module i2c_register_access_master_unit_tb;
  import i2cram_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          NACK_NONE    = -1;
  localparam int          TICKS_NO_CAP = 1000;
  localparam logic [1:0]  OP_UNDEFINED = 2'd3;

  typedef enum int {RD_RANDOM, RD_ONES, RD_ZEROS} rd_pattern_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_LONG} stall_mode_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;
  logic cfg_write;
  logic cfg_index;
  logic [6:0] cfg_data;

  i2c_register_access_master_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bus master model state
  phase_t      bus_phase;
  logic [3:0]  bit_cnt;
  logic [2:0]  byte_sel;
  logic [7:0]  tx_shift;
  logic [15:0] rx_word;
  op_t         cur_op;
  logic [7:0]  cur_ptr;
  logic [15:0] cur_value;
  logic        acked_all;
  logic [6:0]  dev_addr;
  logic        bus_on;

  res_t        line_results_q[$];
  int          error_count;
  int          results_checked;
  int          ticks_sent;
  int          txn_count;
  int          cycles;
  int          burst_left;
  bit          gaps_on;
  int          ack_slot;
  int          stall_hold;
  stall_mode_t stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_bus_model();
    bus_phase = PH_IDLE;
    bit_cnt   = '0;
    byte_sel  = BYTE_ADDR;
    tx_shift  = '0;
    rx_word   = '0;
    cur_op    = OP_PROBE;
    cur_ptr   = '0;
    cur_value = '0;
    acked_all = 1'b1;
    dev_addr  = DEVICE_ADDRESS_RESET;
    bus_on    = 1'b0;
  endfunction

  function automatic logic [7:0] tx_byte(logic [2:0] idx);
    logic [7:0] addr_w;
    addr_w = {dev_addr, 1'b0};
    case (idx)
      BYTE_ADDR:  return addr_w;
      BYTE_PTR:   return cur_ptr;
      BYTE_THIRD: return (cur_op == OP_READ) ? (addr_w | 8'h01) : cur_value[15:8];
      default:    return cur_value[7:0];
    endcase
  endfunction

  function automatic void load_byte(logic [2:0] idx);
    byte_sel  = idx;
    tx_shift  = tx_byte(idx);
    bit_cnt   = '0;
    bus_phase = PH_WBIT_LO;
  endfunction

  // one bus tick: returns the line levels and completion status it produces
  function automatic res_t predict_tick(req_t t);
    res_t r;
    logic scl, sda, busy, done, ok;
    logic [15:0] data;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b1;
    done = 1'b0;
    ok   = 1'b0;
    data = '0;
    case (bus_phase)
      PH_IDLE: begin
        busy = 1'b0;
        if (t.start_req) begin
          if (!bus_on || !(t.op inside {OP_PROBE, OP_WRITE, OP_READ})) begin
            done = 1'b1;
          end else begin
            cur_op    = op_t'(t.op);
            cur_ptr   = t.reg_pointer;
            cur_value = t.write_data;
            rx_word   = '0;
            byte_sel  = BYTE_ADDR;
            bit_cnt   = '0;
            acked_all = 1'b1;
            busy      = 1'b1;
            bus_phase = PH_START_B;
          end
        end
      end
      PH_START_A: bus_phase = PH_START_B;
      PH_START_B: begin
        sda = 1'b0;
        load_byte(byte_sel);
      end
      PH_WBIT_LO: begin
        scl = 1'b0;
        sda = tx_shift[7];
        bus_phase = PH_WBIT_HI;
      end
      PH_WBIT_HI: begin
        sda = tx_shift[7];
        tx_shift = tx_shift << 1;
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= BITS_PER_BYTE) ? PH_WACK_LO : PH_WBIT_LO;
      end
      PH_WACK_LO: begin
        scl = 1'b0;
        bus_phase = PH_WACK_HI;
      end
      PH_WACK_HI: begin
        if (t.sda_sample) begin
          acked_all = 1'b0;
          bus_phase = PH_STOP_A;
        end else begin
          case (cur_op)
            OP_WRITE: begin
              if (byte_sel < BYTE_FOURTH) load_byte(byte_sel + 3'd1);
              else bus_phase = PH_STOP_A;
            end
            OP_READ: begin
              if (byte_sel == BYTE_ADDR) begin
                load_byte(BYTE_PTR);
              end else if (byte_sel == BYTE_PTR) begin
                byte_sel  = BYTE_THIRD;
                bus_phase = PH_START_A;
              end else begin
                byte_sel  = BYTE_FOURTH;
                bit_cnt   = '0;
                bus_phase = PH_RBIT_LO;
              end
            end
            default: bus_phase = PH_STOP_A;
          endcase
        end
      end
      PH_RBIT_LO: begin
        scl = 1'b0;
        bus_phase = PH_RBIT_HI;
      end
      PH_RBIT_HI: begin
        rx_word = {rx_word[14:0], t.sda_sample};
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= BITS_PER_BYTE) ? PH_MACK_LO : PH_RBIT_LO;
      end
      PH_MACK_LO: begin
        scl = 1'b0;
        sda = (byte_sel == BYTE_FOURTH) ? 1'b0 : 1'b1;
        bus_phase = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        sda = (byte_sel == BYTE_FOURTH) ? 1'b0 : 1'b1;
        if (byte_sel == BYTE_FOURTH) begin
          byte_sel  = BYTE_RD_LO;
          bit_cnt   = '0;
          bus_phase = PH_RBIT_LO;
        end else begin
          bus_phase = PH_STOP_A;
        end
      end
      PH_STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
        bus_phase = PH_STOP_B;
      end
      PH_STOP_B: begin
        sda = 1'b0;
        bus_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        done = 1'b1;
        ok   = acked_all;
        data = (acked_all && cur_op == OP_READ) ? rx_word : 16'h0000;
        bus_phase = PH_IDLE;
      end
      default: begin
        busy = 1'b0;
        bus_phase = PH_IDLE;
      end
    endcase
    r.scl_release = scl;
    r.sda_release = sda;
    r.busy_res    = busy;
    r.done_res    = done;
    r.success     = ok;
    r.read_data   = data;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d, t=%0t)",
             what, got, want, results_checked, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (line_results_q.size() == 0) begin
        report_mismatch("result with no request pending", int'(res), 0);
      end else begin
        want = line_results_q.pop_front();
        if (res.scl_release !== want.scl_release)
          report_mismatch("scl_release", int'(res.scl_release), int'(want.scl_release));
        if (res.sda_release !== want.sda_release)
          report_mismatch("sda_release", int'(res.sda_release), int'(want.sda_release));
        if (res.busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(res.busy_res), int'(want.busy_res));
        if (res.done_res !== want.done_res)
          report_mismatch("done_res", int'(res.done_res), int'(want.done_res));
        if (res.success !== want.success)
          report_mismatch("success", int'(res.success), int'(want.success));
        if (res.read_data !== want.read_data)
          report_mismatch("read_data", int'(res.read_data), int'(want.read_data));
      end
      results_checked++;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_hold != 0) begin
          stall_hold--;
          res_stall <= 1'b1;
        end else begin
          res_stall <= 1'b0;
          if ($urandom_range(0, 7) == 0) stall_hold = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               line_results_q.size());
      $display("i2c_register_access_master_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_tick(req_t item);
    if (gaps_on && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    line_results_q.push_back(predict_tick(item));
    ticks_sent++;
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    req_valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEVICE_ADDRESS) dev_addr = val;
    else bus_on = val[0];
  endtask

  // next tick while a transaction runs: acks at ack slots but the NACK slot, read bits by pattern, noise elsewhere
  function automatic req_t make_tick(int nack_slot, rd_pattern_t rd);
    req_t t;
    t.start_req   = 1'($urandom_range(0, 1));
    t.op          = 2'($urandom_range(0, 3));
    t.reg_pointer = 8'($urandom_range(0, 255));
    t.write_data  = 16'($urandom_range(0, 65535));
    t.sda_sample  = 1'($urandom_range(0, 1));
    if (bus_phase == PH_WACK_HI) begin
      t.sda_sample = (ack_slot == nack_slot);
      ack_slot++;
    end else if (bus_phase == PH_RBIT_HI && rd != RD_RANDOM) begin
      t.sda_sample = (rd == RD_ONES);
    end
    return t;
  endfunction

  task automatic start_transaction(logic [1:0] op, logic [7:0] ptr, logic [15:0] value);
    req_t t;
    t.start_req   = 1'b1;
    t.op          = op;
    t.reg_pointer = ptr;
    t.write_data  = value;
    t.sda_sample  = 1'($urandom_range(0, 1));
    ack_slot = 0;
    txn_count++;
    send_tick(t);
  endtask

  task automatic finish_transaction(int nack_slot, rd_pattern_t rd, int max_ticks);
    int n;
    n = 0;
    while (bus_phase != PH_IDLE && n < max_ticks) begin
      send_tick(make_tick(nack_slot, rd));
      n++;
    end
  endtask

  task automatic run_transaction(logic [1:0] op, logic [7:0] ptr, logic [15:0] value,
                                 int nack_slot, rd_pattern_t rd);
    start_transaction(op, ptr, value);
    finish_transaction(nack_slot, rd, TICKS_NO_CAP);
  endtask

  task automatic idle_tick();
    req_t t;
    t = make_tick(NACK_NONE, RD_RANDOM);
    t.start_req = 1'b0;
    send_tick(t);
  endtask

  task automatic test_disabled_bus();
    idle_tick();
    run_transaction(OP_PROBE, 8'h00, 16'h0000, NACK_NONE, RD_RANDOM);
    run_transaction(OP_WRITE, 8'hFF, 16'hFFFF, NACK_NONE, RD_RANDOM);
    run_transaction(OP_READ, 8'h5A, 16'h1234, NACK_NONE, RD_RANDOM);
    run_transaction(OP_UNDEFINED, 8'hA5, 16'h8001, NACK_NONE, RD_RANDOM);
    idle_tick();
  endtask

  task automatic test_probe();
    write_cfg(CFG_BUS_ENABLE, 7'd1);
    write_cfg(CFG_DEVICE_ADDRESS, 7'h7F);
    run_transaction(OP_PROBE, 8'h00, 16'h0000, NACK_NONE, RD_RANDOM);
    run_transaction(OP_PROBE, 8'hFF, 16'hFFFF, 0, RD_RANDOM);
    write_cfg(CFG_DEVICE_ADDRESS, 7'h00);
    run_transaction(OP_PROBE, 8'h3C, 16'h0F0F, NACK_NONE, RD_RANDOM);
  endtask

  task automatic test_register_write();
    write_cfg(CFG_DEVICE_ADDRESS, 7'h55);
    run_transaction(OP_WRITE, 8'hFF, 16'hFFFF, NACK_NONE, RD_RANDOM);
    run_transaction(OP_WRITE, 8'h00, 16'h0000, NACK_NONE, RD_RANDOM);
    for (int s = 0; s < 4; s++)
      run_transaction(OP_WRITE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                      s, RD_RANDOM);
  endtask

  task automatic test_register_read();
    write_cfg(CFG_DEVICE_ADDRESS, 7'h2A);
    run_transaction(OP_READ, 8'hFF, 16'h0000, NACK_NONE, RD_ONES);
    run_transaction(OP_READ, 8'h00, 16'hFFFF, NACK_NONE, RD_ZEROS);
    run_transaction(OP_READ, 8'h81, 16'h0000, NACK_NONE, RD_RANDOM);
    for (int s = 0; s < 3; s++)
      run_transaction(OP_READ, 8'($urandom_range(0, 255)), 16'h0000, s, RD_ONES);
  endtask

  task automatic test_illegal_op();
    run_transaction(OP_UNDEFINED, 8'hFF, 16'hFFFF, NACK_NONE, RD_RANDOM);
    idle_tick();
  endtask

  // address change lands after the first address byte; enable is only sampled at launch
  task automatic test_config_while_busy();
    write_cfg(CFG_DEVICE_ADDRESS, 7'h11);
    start_transaction(OP_READ, 8'h42, 16'h0000);
    finish_transaction(NACK_NONE, RD_RANDOM, 12);
    write_cfg(CFG_DEVICE_ADDRESS, 7'h6E);
    write_cfg(CFG_BUS_ENABLE, 7'd0);
    finish_transaction(NACK_NONE, RD_RANDOM, TICKS_NO_CAP);
    run_transaction(OP_WRITE, 8'h10, 16'hBEEF, NACK_NONE, RD_RANDOM);
    write_cfg(CFG_BUS_ENABLE, 7'd1);
  endtask

  task automatic test_random_traffic();
    int quota, base, pick, nack;
    logic [1:0] op;
    rd_pattern_t rd;
    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_DEVICE_ADDRESS, (p == 0) ? 7'h00 : (p == 1) ? 7'h7F :
                7'($urandom_range(0, 127)));
      write_cfg(CFG_BUS_ENABLE, (p == 3) ? 7'd0 : 7'd1);
      gaps_on    = (p % 3 != 0);
      stall_mode = stall_mode_t'(p % 3);
      quota      = (p == 3) ? 30 : 90;
      base       = ticks_sent;
      while (ticks_sent - base < quota) begin
        if ($urandom_range(0, 9) == 0) idle_tick();
        pick = $urandom_range(0, 19);
        op   = (pick < 4) ? OP_PROBE : (pick < 11) ? OP_WRITE :
               (pick < 19) ? OP_READ : OP_UNDEFINED;
        nack = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : NACK_NONE;
        rd   = rd_pattern_t'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
        run_transaction(op, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        nack, rd);
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req        <= '0;
    res_stall  <= 1'b0;
    cfg_write  <= 1'b0;
    cfg_index  <= CFG_DEVICE_ADDRESS;
    cfg_data   <= '0;
    stall_mode = STALL_NONE;
    stall_hold = 0;
    gaps_on    = 1'b0;
    burst_left = 0;
    cycles     = 0;
    error_count = 0;
    results_checked = 0;
    ticks_sent = 0;
    txn_count  = 0;
    reset_bus_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_bus();
    test_probe();
    stall_mode = STALL_LIGHT;
    gaps_on    = 1'b1;
    test_register_write();
    stall_mode = STALL_LONG;
    test_register_read();
    test_illegal_op();
    test_config_while_busy();
    test_random_traffic();

    req_valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d transactions (probe, write, read, undefined op, disabled bus,",
             txn_count);
    $display("  NACK on each byte) over %0d bus ticks, %0d results compared",
             ticks_sent, results_checked);
    if (error_count == 0) begin
      $display("i2c_register_access_master_unit_tb: done, clean");
    end else begin
      $display("i2c_register_access_master_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
